// File: hw/rtl/control_frame_parser_crc32_top_defines.svh
// Assertion macros for the checker file of the frame parser.
// Each macro expects a signal named clock, and the first two one named reset, in the scope where it is used.
`ifndef CONTROL_FRAME_PARSER_CRC32_TOP_DEFINES_SVH
`define CONTROL_FRAME_PARSER_CRC32_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CFP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CFP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cfp_pkg.sv
package cfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h05;
   localparam logic [7:0] HDR_SECOND = 8'h0A;
   localparam logic [7:0] FTR_FIRST  = 8'h50;
   localparam logic [7:0] FTR_SECOND = 8'hA0;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [7:0] SETTING_MIN = 8'd1;
   localparam logic [7:0] SETTING_MAX = 8'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FOOTER  = 2'd2;
   localparam logic [1:0] ST_CRC     = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [7:0]  setting_id;
      logic [15:0] setting_value;
      logic [1:0]  frame_status;
   } result_type;

   // Reflected CRC-32 update over one byte, least significant bit first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h00000000);
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/cfp_parse.sv
module cfp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output cfp_pkg::result_type res
);

   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_HDR2  = 4'd1;
   localparam logic [3:0] PH_SET   = 4'd2;
   localparam logic [3:0] PH_VALHI = 4'd3;
   localparam logic [3:0] PH_VALLO = 4'd4;
   localparam logic [3:0] PH_CRC0  = 4'd5;
   localparam logic [3:0] PH_CRC1  = 4'd6;
   localparam logic [3:0] PH_CRC2  = 4'd7;
   localparam logic [3:0] PH_CRC3  = 4'd8;
   localparam logic [3:0] PH_FTR1  = 4'd9;
   localparam logic [3:0] PH_FTR2  = 4'd10;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  setting_ff, setting_in;
   logic [15:0] value_ff, value_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_crc_ff, rcv_crc_in;
   logic [31:0] crc_next;

   assign crc_next = cfp_pkg::crc_byte(crc_ff, rx_byte);

   always_comb begin
      phase_in   = phase_ff;
      setting_in = setting_ff;
      value_in   = value_ff;
      crc_in     = crc_ff;
      rcv_crc_in = rcv_crc_ff;
      res.valid         = 1'b0;
      res.setting_id    = setting_ff;
      res.setting_value = value_ff;
      res.frame_status  = cfp_pkg::ST_OK;
      unique case (phase_ff) inside
         PH_HDR2: begin
            if (rx_byte == cfp_pkg::HDR_SECOND) begin
               crc_in   = cfp_pkg::CRC_INIT;
               phase_in = PH_SET;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_SET: begin
            setting_in = rx_byte;
            crc_in     = crc_next;
            phase_in   = PH_VALHI;
         end
         PH_VALHI: begin
            value_in = {rx_byte, 8'h00};
            crc_in   = crc_next;
            phase_in = PH_VALLO;
         end
         PH_VALLO: begin
            value_in = {value_ff[15:8], rx_byte};
            crc_in   = crc_next;
            phase_in = PH_CRC0;
         end
         PH_CRC0, PH_CRC1, PH_CRC2, PH_CRC3: begin
            rcv_crc_in = {rcv_crc_ff[23:0], rx_byte};
            phase_in   = phase_ff + 4'd1;
         end
         PH_FTR1: begin
            if (rx_byte != cfp_pkg::FTR_FIRST) begin
               res.valid        = 1'b1;
               res.frame_status = cfp_pkg::ST_FOOTER;
               phase_in         = PH_HUNT;
            end else begin
               phase_in = PH_FTR2;
            end
         end
         PH_FTR2: begin
            res.valid = 1'b1;
            phase_in  = PH_HUNT;
            // Footer errors take priority over a CRC mismatch.
            if (rx_byte != cfp_pkg::FTR_SECOND) begin
               res.frame_status = cfp_pkg::ST_FOOTER;
            end else if ((crc_ff ^ cfp_pkg::CRC_INIT) != rcv_crc_ff) begin
               res.frame_status = cfp_pkg::ST_CRC;
            end else if (setting_ff >= cfp_pkg::SETTING_MIN &&
                         setting_ff <= cfp_pkg::SETTING_MAX) begin
               res.frame_status = cfp_pkg::ST_OK;
            end else begin
               res.frame_status = cfp_pkg::ST_UNKNOWN;
            end
         end
         default: begin
            // Hunting; unused phase codes behave the same way.
            phase_in = (rx_byte == cfp_pkg::HDR_FIRST) ? PH_HDR2 : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         setting_ff <= 8'h00;
         value_ff   <= 16'h0000;
         crc_ff     <= cfp_pkg::CRC_INIT;
         rcv_crc_ff <= 32'h00000000;
      end else if (step) begin
         phase_ff   <= phase_in;
         setting_ff <= setting_in;
         value_ff   <= value_in;
         crc_ff     <= crc_in;
         rcv_crc_ff <= rcv_crc_in;
      end
   end

endmodule

// File: hw/rtl/control_frame_parser_crc32_top.sv
// Channel   Direction  Word
// req       in         tdata[7:0] rx_byte
// rsp       out        tdata[7:0] setting_id, tdata[23:8] setting_value,
//                      tuser[1:0] frame_status
//
// One byte is taken per cycle while the result side is not stalled; a byte is held in the
// input register and is then parsed into the result register, which takes the result of a
// frame once its last footer byte has passed through the input register.
// The rate is set by the combinational CRC byte update in the frame parser.
// Reset is synchronous and returns the parser to hunting for a header.
// While a result waits on rsp_tready, the input register still accepts one byte if it is empty.
module control_frame_parser_crc32_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] setting_id, [23:8] setting_value
   output logic [1:0]  rsp_tuser    // [1:0] frame_status
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic [23:0]          out_data_ff;
   logic [1:0]           out_user_ff;
   logic                 out_free;
   logic                 step;
   cfp_pkg::result_type  res;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   cfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= step && res.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (step && res.valid) begin
         out_data_ff <= {res.setting_value, res.setting_id};
         out_user_ff <= res.frame_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// File: hw/rtl/cfp_checker.sv
`include "control_frame_parser_crc32_top_defines.svh"

module cfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic known;

   assign known = rsp_tdata[7:0] >= cfp_pkg::SETTING_MIN &&
                  rsp_tdata[7:0] <= cfp_pkg::SETTING_MAX;

   // An accepted frame must carry one of the known settings.
   `CFP_ASSERT_IMP(ok_needs_known, rsp_tvalid && rsp_tuser == cfp_pkg::ST_OK, known, "accepted frame with unknown setting")

   // An unknown-setting status must not name a known setting.
   `CFP_ASSERT_IMP(unknown_not_known, rsp_tvalid && rsp_tuser == cfp_pkg::ST_UNKNOWN, !known, "unknown status on known setting")

   // A ready result side always lets the input side take a word.
   `CFP_ASSERT_IMP(rsp_ready_frees_req, rsp_tready, req_tready, "input stalled while result side ready")

   // Reset leaves no result pending.
   `CFP_ASSERT_NEXT_ALWAYS(reset_clears_rsp, reset, !rsp_tvalid, "result visible after reset")

   // A stalled result word holds.
   `CFP_ASSERT_NEXT(rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind control_frame_parser_crc32_top cfp_checker u_cfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: bench/tb_top.sv
module tb_top;

   typedef enum logic [3:0] {
      HUNT_HDR1, HUNT_HDR2, TAKE_SETTING, TAKE_VALUE_HI, TAKE_VALUE_LO,
      TAKE_CRC_B3, TAKE_CRC_B2, TAKE_CRC_B1, TAKE_CRC_B0, TAKE_FTR1, TAKE_FTR2
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]  setting;
      logic [15:0] value;
      logic [1:0]  status;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]       rx;
      logic             typed;
      frame_result_type want;
   } stim_row_type;

   localparam int PHASE_BYTES = 640;

   // Rows with typed set carry a result that can be read straight off the frame.
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{8'h00, 1'b0, '0},                      // stray bytes while hunting
      '{8'hFF, 1'b0, '0},
      '{cfp_pkg::HDR_FIRST, 1'b0, '0},         // header broken by a second 0x05
      '{cfp_pkg::HDR_FIRST, 1'b0, '0},
      '{cfp_pkg::HDR_SECOND, 1'b0, '0},        // must be dropped, not taken as header
      '{cfp_pkg::HDR_FIRST, 1'b0, '0},
      '{cfp_pkg::HDR_SECOND, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{8'hFF, 16'hFFFF, cfp_pkg::ST_FOOTER}},
      '{cfp_pkg::HDR_FIRST, 1'b0, '0},
      '{cfp_pkg::HDR_SECOND, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{cfp_pkg::FTR_FIRST, 1'b0, '0},
      '{cfp_pkg::FTR_SECOND, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int unsigned      req_idle_pct = 36;
   int unsigned      rsp_idle_pct = 85;
   int unsigned      error_count = 0;
   int unsigned      bytes_sent = 0;
   frame_result_type awaited_frames [$];

   // Parser state mirrored from the block.
   parse_phase_type  parse_phase = HUNT_HDR1;
   logic [7:0]       latched_setting = 8'h00;
   logic [15:0]      latched_value = 16'h0000;
   logic [31:0]      crc_acc = cfp_pkg::CRC_INIT;
   logic [31:0]      crc_wire = 32'h00000000;

   control_frame_parser_crc32_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      acc = crc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         acc = acc[0] ? ((acc >> 1) ^ cfp_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   task automatic advance_parser(input logic [7:0] b, output bit produced,
                                 output frame_result_type res);
      produced = 1'b0;
      res = '0;
      case (parse_phase)
         HUNT_HDR2: begin
            if (b == cfp_pkg::HDR_SECOND) begin
               crc_acc = cfp_pkg::CRC_INIT;
               parse_phase = TAKE_SETTING;
            end else begin
               parse_phase = HUNT_HDR1;
            end
         end
         TAKE_SETTING: begin
            latched_setting = b;
            crc_acc = crc32_step(crc_acc, b);
            parse_phase = TAKE_VALUE_HI;
         end
         TAKE_VALUE_HI: begin
            latched_value = {b, 8'h00};
            crc_acc = crc32_step(crc_acc, b);
            parse_phase = TAKE_VALUE_LO;
         end
         TAKE_VALUE_LO: begin
            latched_value[7:0] = b;
            crc_acc = crc32_step(crc_acc, b);
            parse_phase = TAKE_CRC_B3;
         end
         TAKE_CRC_B3: begin
            crc_wire = {crc_wire[23:0], b};
            parse_phase = TAKE_CRC_B2;
         end
         TAKE_CRC_B2: begin
            crc_wire = {crc_wire[23:0], b};
            parse_phase = TAKE_CRC_B1;
         end
         TAKE_CRC_B1: begin
            crc_wire = {crc_wire[23:0], b};
            parse_phase = TAKE_CRC_B0;
         end
         TAKE_CRC_B0: begin
            crc_wire = {crc_wire[23:0], b};
            parse_phase = TAKE_FTR1;
         end
         TAKE_FTR1: begin
            if (b != cfp_pkg::FTR_FIRST) begin
               produced = 1'b1;
               res = '{latched_setting, latched_value, cfp_pkg::ST_FOOTER};
               parse_phase = HUNT_HDR1;
            end else begin
               parse_phase = TAKE_FTR2;
            end
         end
         TAKE_FTR2: begin
            produced = 1'b1;
            res = '{latched_setting, latched_value, cfp_pkg::ST_OK};
            // A bad footer hides a bad CRC.
            if (b != cfp_pkg::FTR_SECOND) begin
               res.status = cfp_pkg::ST_FOOTER;
            end else if ((crc_acc ^ cfp_pkg::CRC_INIT) != crc_wire) begin
               res.status = cfp_pkg::ST_CRC;
            end else if (latched_setting < cfp_pkg::SETTING_MIN ||
                         latched_setting > cfp_pkg::SETTING_MAX) begin
               res.status = cfp_pkg::ST_UNKNOWN;
            end
            parse_phase = HUNT_HDR1;
         end
         default: begin
            parse_phase = (b == cfp_pkg::HDR_FIRST) ? HUNT_HDR2 : HUNT_HDR1;
         end
      endcase
   endtask

   // Presents one word, waits for it to be taken and records what it should cause.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_result_type want);
      bit               produced;
      frame_result_type res;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      advance_parser(b, produced, res);
      if (typed) begin
         awaited_frames.push_back(want);
      end else if (produced) begin
         awaited_frames.push_back(res);
      end
   endtask

   task automatic send_random_burst();
      logic [7:0]  burst [$];
      logic [7:0]  setting;
      logic [15:0] value;
      logic [31:0] crc;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         setting = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(1, 7))
                                                : 8'($urandom_range(0, 255));
         value = 16'($urandom_range(0, 65535));
         crc = crc32_step(crc32_step(crc32_step(cfp_pkg::CRC_INIT, setting), value[15:8]),
                          value[7:0]);
         crc = crc ^ cfp_pkg::CRC_INIT;
         if ($urandom_range(0, 9) == 0) begin
            crc = crc ^ (32'h1 << $urandom_range(0, 31));
         end
         burst = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, setting, value[15:8], value[7:0],
                  crc[31:24], crc[23:16], crc[15:8], crc[7:0],
                  cfp_pkg::FTR_FIRST, cfp_pkg::FTR_SECOND};
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            // Wrong first footer byte; the second one is then hunted as a fresh byte.
            burst[9] = 8'($urandom_range(0, 254));
            if (burst[9] >= cfp_pkg::FTR_FIRST) burst[9] = burst[9] + 8'd1;
         end else if (pick < 14) begin
            burst[10] = 8'($urandom_range(0, 254));
            if (burst[10] >= cfp_pkg::FTR_SECOND) burst[10] = burst[10] + 8'd1;
         end else if (pick < 20) begin
            burst[9]  = 8'($urandom_range(0, 255));
            burst[10] = 8'($urandom_range(0, 255));
         end
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         burst.push_back(cfp_pkg::HDR_FIRST);
         burst.push_back(($urandom_range(0, 3) == 0) ? cfp_pkg::HDR_FIRST
                                                     : 8'($urandom_range(0, 255)));
      end else begin
         // Truncated frame: whatever follows is parsed as its remaining fields.
         burst = {cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND};
         repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
      end
      foreach (burst[k]) send_byte(burst[k], 1'b0, '0);
   endtask

   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_frames.size() == 0) begin
            $display("%0t: result with none expected: setting %h value %h status %0d",
                     $time, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser);
            error_count++;
         end else begin
            want = awaited_frames.pop_front();
            if (rsp_tdata[7:0] !== want.setting) begin
               $display("%0t: setting_id expected %h actual %h",
                        $time, want.setting, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[23:8] !== want.value) begin
               $display("%0t: setting_value expected %h actual %h",
                        $time, want.value, rsp_tdata[23:8]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: frame_status expected %0d actual %0d",
                        $time, want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #400000;
      $display("control_frame_parser_crc32_top regression: fail");
      $finish;
   end

   initial begin
      int unsigned wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED_ROWS[r]) begin
         send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 36; rsp_idle_pct = 85; end
            1: begin req_idle_pct = 85; rsp_idle_pct = 36; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) send_random_burst();
      end
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (awaited_frames.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (awaited_frames.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited_frames.size());
         error_count++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("control_frame_parser_crc32_top regression: pass");
      end else begin
         $display("control_frame_parser_crc32_top regression: fail");
      end
      $finish;
   end

endmodule

// File: control_frame_parser_crc32_top.f
+incdir+hw/rtl
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_parse.sv
hw/rtl/control_frame_parser_crc32_top.sv
hw/rtl/cfp_checker.sv
bench/tb_top.sv
